>>> hw/rtl/htnt_pkg.sv
package htnt_pkg;

  // field widths
  localparam int unsigned NODE_W  = 12;
  localparam int unsigned WORD_W  = 24;
  localparam int unsigned EPOCH_W = 8;
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned LIMIT_W = 12;

  localparam int unsigned LOG_SIZE_DEF = 12;

  localparam logic [31:0]        HASH_MUL       = 32'h9E37_79B9;
  localparam logic [WORD_W-1:0]  ROOT_WORD      = 24'hFF_FFFF;
  localparam logic [EPOCH_W-1:0] EPOCH_PERSIST  = 8'd0;
  localparam logic [EPOCH_W-1:0] EPOCH_EMPTY    = 8'd1;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST    = 8'd2;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST     = 8'd255;
  localparam logic [CNT_W-1:0]   COUNT_MAX      = 13'd8191;
  localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RST = 12'd3276;

  typedef enum logic [1:0] {
    REQ_EPHEMERAL  = 2'd0,
    REQ_PERSISTENT = 2'd1,
    REQ_LOOKUP     = 2'd2,
    REQ_CLEAR      = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_FOUND      = 3'd0,
    ST_INSERTED   = 3'd1,
    ST_NOT_FOUND  = 3'd2,
    ST_OVERFLOW   = 3'd3,
    ST_CLEAR_DONE = 3'd4
  } status_e;

  typedef struct packed {
    logic [NODE_W-1:0]  parent;
    logic [WORD_W-1:0]  word;
    logic [EPOCH_W-1:0] epoch;
  } entry_t;

  localparam entry_t ENTRY_EMPTY = '{parent: '0, word: '0, epoch: EPOCH_EMPTY};
  localparam entry_t ENTRY_ROOT  = '{parent: '0, word: ROOT_WORD, epoch: EPOCH_PERSIST};

endpackage

>>> hw/rtl/htnt_if.sv
interface htnt_req_if import htnt_pkg::*;;
  logic              valid;
  logic              ready;
  req_e              req_type;
  logic [NODE_W-1:0] parent_node;
  logic [WORD_W-1:0] edge_word;

  modport source (output valid, output req_type, output parent_node, output edge_word,
                  input ready);
  modport sink   (input valid, input req_type, input parent_node, input edge_word,
                  output ready);
endinterface

interface htnt_rsp_if import htnt_pkg::*;;
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] child_node;
  status_e           status;

  modport source (output valid, output child_node, output status, input ready);
  modport sink   (input valid, input child_node, input status, output ready);
endinterface

interface htnt_cfg_if import htnt_pkg::*;;
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] load_limit;

  modport source (output valid, output load_limit, input ready);
  modport sink   (input valid, input load_limit, output ready);
endinterface

>>> hw/rtl/htnt_mem.sv
module htnt_mem import htnt_pkg::*; #(
  parameter int unsigned AddrW = LOG_SIZE_DEF
) (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output entry_t           rdata_o,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  entry_t           wdata_i
);

  localparam int unsigned Depth = 1 << AddrW;

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/htnt_hash.sv
module htnt_hash import htnt_pkg::*; #(
  parameter int unsigned LogSize = LOG_SIZE_DEF
) (
  input  logic               clk_i,
  input  logic [NODE_W-1:0]  node_i,
  input  logic [WORD_W-1:0]  word_i,
  output logic [LogSize-1:0] home_o
);

  localparam int unsigned ProdW = NODE_W + LogSize;

  // only the low LogSize bits of the product reach the slot index
  logic [ProdW-1:0]   prod;
  logic [LogSize-1:0] home_d, home_q;

  assign prod   = ProdW'(node_i) * ProdW'(HASH_MUL[LogSize-1:0]);
  assign home_d = prod[LogSize-1:0] ^ word_i[LogSize-1:0];

  always_ff @(posedge clk_i) begin
    home_q <= home_d;
  end

  assign home_o = home_q;

endmodule

>>> hw/rtl/htnt_ctrl.sv
module htnt_ctrl import htnt_pkg::*; #(
  parameter int unsigned LogSize = LOG_SIZE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  req_e               in_req_type_i,
  input  logic [NODE_W-1:0]  in_parent_node_i,
  input  logic [WORD_W-1:0]  in_edge_word_i,
  // response channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [NODE_W-1:0]  out_child_node_o,
  output status_e            out_status_o,
  // load limit write
  input  logic               cfg_valid_i,
  input  logic [LIMIT_W-1:0] cfg_load_limit_i,
  // hash unit
  output logic [NODE_W-1:0]  hash_node_o,
  output logic [WORD_W-1:0]  hash_word_o,
  input  logic [LogSize-1:0] hash_home_i,
  // table memory
  output logic               mem_re_o,
  output logic [LogSize-1:0] mem_raddr_o,
  input  entry_t             mem_rdata_i,
  output logic               mem_we_o,
  output logic [LogSize-1:0] mem_waddr_o,
  output entry_t             mem_wdata_o
);

  localparam int unsigned IdxExtW = (LogSize > NODE_W) ? LogSize : NODE_W;

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_HASH  = 7'b0000100,
    S_PROBE = 7'b0001000,
    S_CHECK = 7'b0010000,
    S_SWEEP = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_e;

  state_e              state_q, state_d;
  logic [LogSize:0]    cnt_q, cnt_d;
  logic [LogSize-1:0]  idx_q, idx_d;
  logic [EPOCH_W-1:0]  epoch_q, epoch_d;
  logic [CNT_W-1:0]    live_q, live_d;
  logic [CNT_W-1:0]    rem_q, rem_d;
  logic                out_valid_q, out_valid_d;
  logic                sw_vld_q, sw_vld_d;
  logic [LogSize-1:0]  sw_addr_q;

  // payload registers
  req_e                req_q;
  logic [NODE_W-1:0]   node_q;
  logic [WORD_W-1:0]   word_q;
  logic [NODE_W-1:0]   out_child_q, out_child_d;
  status_e             out_status_q, out_status_d;
  logic [NODE_W-1:0]   res_child_q, res_child_d;
  status_e             res_status_q, res_status_d;

  logic                accept;
  logic                out_free;
  logic                load_out;
  logic [LogSize-1:0]  idx_next;
  logic [IdxExtW-1:0]  idx_ext;
  logic                key_match, is_persist, is_live, probe_last;
  logic                chk_done;
  logic [NODE_W-1:0]   chk_child;
  status_e             chk_status;
  logic [CNT_W-1:0]    live_inc, rem_dec;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign hash_node_o = node_q;
  assign hash_word_o = word_q;

  assign idx_next   = idx_q + (word_q[LogSize-1:0] | LogSize'(1));
  assign idx_ext    = IdxExtW'(idx_q);
  assign key_match  = (mem_rdata_i.parent == node_q) && (mem_rdata_i.word == word_q);
  assign is_persist = (mem_rdata_i.epoch == EPOCH_PERSIST);
  assign is_live    = is_persist || (mem_rdata_i.epoch == epoch_q);
  assign probe_last = (cnt_q[LogSize-1:0] == '1);
  assign live_inc   = (live_q == COUNT_MAX) ? live_q : live_q + CNT_W'(1);
  assign rem_dec    = (rem_q == '0) ? rem_q : rem_q - CNT_W'(1);

  // decision on the slot just read
  always_comb begin
    chk_done   = 1'b0;
    chk_child  = '0;
    chk_status = ST_NOT_FOUND;
    case (req_q)
      REQ_PERSISTENT: begin
        if (!is_persist) begin
          chk_done   = 1'b1;
          chk_child  = idx_ext[NODE_W-1:0];
          chk_status = (live_q > rem_dec) ? ST_OVERFLOW : ST_INSERTED;
        end else if (key_match) begin
          chk_done   = 1'b1;
          chk_child  = idx_ext[NODE_W-1:0];
          chk_status = ST_FOUND;
        end else if (probe_last) begin
          chk_done   = 1'b1;
          chk_status = ST_OVERFLOW;
        end
      end
      REQ_EPHEMERAL, REQ_LOOKUP: begin
        if (is_live && key_match) begin
          chk_done   = 1'b1;
          chk_child  = idx_ext[NODE_W-1:0];
          chk_status = ST_FOUND;
        end else if (!is_live) begin
          chk_done = 1'b1;
          if (req_q == REQ_EPHEMERAL) begin
            chk_child  = idx_ext[NODE_W-1:0];
            chk_status = (live_inc > rem_q) ? ST_OVERFLOW : ST_INSERTED;
          end
        end else if (probe_last) begin
          chk_done   = 1'b1;
          chk_status = (req_q == REQ_EPHEMERAL) ? ST_OVERFLOW : ST_NOT_FOUND;
        end
      end
      default: begin
        chk_done   = 1'b1;
        chk_status = ST_CLEAR_DONE;
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    epoch_d      = epoch_q;
    live_d       = live_q;
    rem_d        = rem_q;
    sw_vld_d     = 1'b0;
    res_child_d  = res_child_q;
    res_status_d = res_status_q;
    load_out     = 1'b0;
    mem_re_o     = 1'b0;
    mem_raddr_o  = idx_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = idx_q;
    mem_wdata_o  = ENTRY_EMPTY;

    case (state_q)
      S_INIT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = cnt_q[LogSize-1:0];
        mem_wdata_o = (cnt_q[LogSize-1:0] == '0) ? ENTRY_ROOT : ENTRY_EMPTY;
        if (cnt_q[LogSize-1:0] == '1) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + (LogSize+1)'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        cnt_d = '0;
        if (req_q == REQ_CLEAR) begin
          live_d       = '0;
          res_child_d  = '0;
          res_status_d = ST_CLEAR_DONE;
          if (epoch_q == EPOCH_LAST) begin
            epoch_d = EPOCH_FIRST;
            state_d = S_SWEEP;
          end else begin
            epoch_d = epoch_q + EPOCH_W'(1);
            state_d = S_EMIT;
          end
        end else begin
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = hash_home_i;
        idx_d       = hash_home_i;
        state_d     = S_CHECK;
      end
      S_CHECK: begin
        if (chk_done) begin
          if (req_q == REQ_PERSISTENT && !is_persist) begin
            mem_we_o    = 1'b1;
            mem_wdata_o = '{parent: node_q, word: word_q, epoch: EPOCH_PERSIST};
            rem_d       = rem_dec;
          end else if (req_q == REQ_EPHEMERAL && !is_live) begin
            mem_we_o    = 1'b1;
            mem_wdata_o = '{parent: node_q, word: word_q, epoch: epoch_q};
            live_d      = live_inc;
          end
          res_child_d  = chk_child;
          res_status_d = chk_status;
          if (out_free) begin
            load_out = 1'b1;
            state_d  = S_IDLE;
          end else begin
            state_d = S_EMIT;
          end
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_next;
          idx_d       = idx_next;
          cnt_d       = cnt_q + (LogSize+1)'(1);
        end
      end
      S_SWEEP: begin
        // read slot i while slot i-1 is written back
        if (!cnt_q[LogSize]) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = cnt_q[LogSize-1:0];
          sw_vld_d    = 1'b1;
          cnt_d       = cnt_q + (LogSize+1)'(1);
        end
        if (sw_vld_q && !is_persist) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = sw_addr_q;
          mem_wdata_o = ENTRY_EMPTY;
        end
        if (cnt_q[LogSize] && !sw_vld_q) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_valid_i) begin
      rem_d = CNT_W'(cfg_load_limit_i);
    end
  end

  always_comb begin
    out_child_d  = out_child_q;
    out_status_d = out_status_q;
    if (load_out) begin
      out_child_d  = (state_q == S_EMIT) ? res_child_q : chk_child;
      out_status_d = (state_q == S_EMIT) ? res_status_q : chk_status;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      epoch_q     <= EPOCH_FIRST;
      live_q      <= '0;
      rem_q       <= CNT_W'(LOAD_LIMIT_RST);
      out_valid_q <= 1'b0;
      sw_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      epoch_q     <= epoch_d;
      live_q      <= live_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
      sw_vld_q    <= sw_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= in_req_type_i;
      node_q <= in_parent_node_i;
      word_q <= in_edge_word_i;
    end
    idx_q        <= idx_d;
    sw_addr_q    <= cnt_q[LogSize-1:0];
    res_child_q  <= res_child_d;
    res_status_q <= res_status_d;
    out_child_q  <= out_child_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o      = out_valid_q;
  assign out_child_node_o = out_child_q;
  assign out_status_o     = out_status_q;

endmodule

>>> hw/rtl/hashed_trie_node_table_core.sv
// item flow: accept, registered hash of the home slot, read of the home slot, decide; every
//   further slot probed adds a read and decide step (at most 2^LogSize slots)
// one item at a time: a new item is accepted only once the last result is loaded for output;
//   clear steps the epoch, and when the epoch wraps it also empties every non-persistent slot
// reset: a clearing pass writes all slots empty and the root into
//   slot 0; no item is accepted until it ends, load limit writes are taken
module hashed_trie_node_table_core import htnt_pkg::*; #(
  parameter int unsigned LogSize = LOG_SIZE_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  htnt_req_if.sink   req_i,
  htnt_rsp_if.source rsp_o,
  htnt_cfg_if.sink   cfg_i
);

  // hash unit <-> controller
  logic [NODE_W-1:0]  hash_node;
  logic [WORD_W-1:0]  hash_word;
  logic [LogSize-1:0] hash_home;

  // table memory port
  logic               mem_re;
  logic [LogSize-1:0] mem_raddr;
  entry_t             mem_rdata;
  logic               mem_we;
  logic [LogSize-1:0] mem_waddr;
  entry_t             mem_wdata;

  // load limit is always writable; it only reloads the remaining limit
  assign cfg_i.ready = 1'b1;

  // registered home slot: (parent * golden ratio) xor word, masked
  htnt_hash #(
    .LogSize (LogSize)
  ) u_hash (
    .clk_i  (clk_i),
    .node_i (hash_node),
    .word_i (hash_word),
    .home_o (hash_home)
  );

  // node table: parent, edge word and epoch per slot
  htnt_mem #(
    .AddrW (LogSize)
  ) u_mem (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata)
  );

  // probe sequencer, epoch and counters, response register
  htnt_ctrl #(
    .LogSize (LogSize)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (req_i.valid),
    .in_ready_o       (req_i.ready),
    .in_req_type_i    (req_i.req_type),
    .in_parent_node_i (req_i.parent_node),
    .in_edge_word_i   (req_i.edge_word),
    .out_valid_o      (rsp_o.valid),
    .out_ready_i      (rsp_o.ready),
    .out_child_node_o (rsp_o.child_node),
    .out_status_o     (rsp_o.status),
    .cfg_valid_i      (cfg_i.valid),
    .cfg_load_limit_i (cfg_i.load_limit),
    .hash_node_o      (hash_node),
    .hash_word_o      (hash_word),
    .hash_home_i      (hash_home),
    .mem_re_o         (mem_re),
    .mem_raddr_o      (mem_raddr),
    .mem_rdata_i      (mem_rdata),
    .mem_we_o         (mem_we),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata)
  );

endmodule

>>> hw/rtl/htnt_checker.sv
module htnt_checker import htnt_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [NODE_W-1:0] out_child_node_i,
  input status_e           out_status_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_child_node_i) && $stable(out_status_i))
    else $error("result changed while stalled");

  // one item in flight: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("item accepted while another is in flight");

  a_clear_child: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == ST_CLEAR_DONE |-> out_child_node_i == '0)
    else $error("clear result with nonzero child");

  a_miss_child: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i == ST_NOT_FOUND |-> out_child_node_i == '0)
    else $error("not found result with nonzero child");

endmodule

bind hashed_trie_node_table_core htnt_checker u_htnt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (req_i.valid),
  .in_ready_i       (req_i.ready),
  .out_valid_i      (rsp_o.valid),
  .out_ready_i      (rsp_o.ready),
  .out_child_node_i (rsp_o.child_node),
  .out_status_i     (rsp_o.status)
);

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import htnt_pkg::*;

  localparam int unsigned SLOTS       = 1 << LOG_SIZE_DEF;
  localparam int          STALL_LIMIT = 20000;  // covers reset clearing pass and epoch sweeps
  localparam int          RSP_HOLD    = 300;    // long back-pressure stretch on the result side
  localparam int          KEY_KEEP    = 48;
  localparam int          NODE_KEEP   = 64;

  typedef struct packed {
    logic [NODE_W-1:0] child;
    status_e           status;
  } answer_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [WORD_W-1:0] word;
  } key_t;

  // one directed item: request, and the result where it is obvious
  typedef struct packed {
    req_e              rq;
    logic [NODE_W-1:0] node;
    logic [WORD_W-1:0] word;
    logic              typed;
    logic [NODE_W-1:0] child;
    status_e           status;
  } probe_row_t;

  localparam answer_t NO_ANSWER = '{child: '0, status: ST_FOUND};

  localparam int N_ROWS = 25;
  localparam probe_row_t DIRECTED [N_ROWS] = '{
    // root key does not sit at its home slot, so it is not found
    '{REQ_LOOKUP,     12'h000, 24'hFFFFFF, 1'b1, 12'd0, ST_NOT_FOUND},
    // home slot 0 holds the root, next slot empty
    '{REQ_LOOKUP,     12'h000, 24'h000000, 1'b1, 12'd0, ST_NOT_FOUND},
    '{REQ_EPHEMERAL,  12'h000, 24'h000000, 1'b1, 12'd1, ST_INSERTED},
    '{REQ_EPHEMERAL,  12'h000, 24'h000000, 1'b1, 12'd1, ST_FOUND},
    '{REQ_LOOKUP,     12'h000, 24'h000000, 1'b1, 12'd1, ST_FOUND},
    // persistent request lands on its own ephemeral copy and pins it
    '{REQ_PERSISTENT, 12'h000, 24'h000000, 1'b1, 12'd1, ST_INSERTED},
    '{REQ_PERSISTENT, 12'h000, 24'h000000, 1'b1, 12'd1, ST_FOUND},
    '{REQ_CLEAR,      12'h000, 24'h000000, 1'b1, 12'd0, ST_CLEAR_DONE},
    '{REQ_EPHEMERAL,  12'h000, 24'h000005, 1'b1, 12'd5, ST_INSERTED},
    '{REQ_CLEAR,      12'hFFF, 24'hFFFFFF, 1'b1, 12'd0, ST_CLEAR_DONE},
    // entry from the previous epoch is stale
    '{REQ_LOOKUP,     12'h000, 24'h000005, 1'b1, 12'd0, ST_NOT_FOUND},
    '{REQ_EPHEMERAL,  12'h000, 24'h000005, 1'b1, 12'd5, ST_INSERTED},
    // field extremes
    '{REQ_EPHEMERAL,  12'hFFF, 24'hFFFFFF, 1'b0, 12'd0, ST_FOUND},
    '{REQ_PERSISTENT, 12'hFFF, 24'h000000, 1'b0, 12'd0, ST_FOUND},
    '{REQ_LOOKUP,     12'hFFF, 24'hFFFFFF, 1'b0, 12'd0, ST_FOUND},
    // same home slot as word 5, walks the probe chain
    '{REQ_EPHEMERAL,  12'h000, 24'h001005, 1'b0, 12'd0, ST_FOUND},
    '{REQ_LOOKUP,     12'h000, 24'h001005, 1'b0, 12'd0, ST_FOUND},
    // persistent insert overwrites a live ephemeral entry
    '{REQ_PERSISTENT, 12'h000, 24'h002005, 1'b0, 12'd0, ST_FOUND},
    '{REQ_LOOKUP,     12'h000, 24'h000005, 1'b0, 12'd0, ST_FOUND},
    '{REQ_EPHEMERAL,  12'h800, 24'hABCDEF, 1'b0, 12'd0, ST_FOUND},
    '{REQ_LOOKUP,     12'h555, 24'h5A5A5A, 1'b0, 12'd0, ST_FOUND},
    '{REQ_PERSISTENT, 12'hAAA, 24'hA5A5A5, 1'b0, 12'd0, ST_FOUND},
    '{REQ_CLEAR,      12'h555, 24'hAAAAAA, 1'b1, 12'd0, ST_CLEAR_DONE},
    '{REQ_LOOKUP,     12'h000, 24'h001005, 1'b0, 12'd0, ST_FOUND},
    '{REQ_EPHEMERAL,  12'h000, 24'hFFFFFF, 1'b0, 12'd0, ST_FOUND}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  htnt_req_if req_if ();
  htnt_rsp_if rsp_if ();
  htnt_cfg_if cfg_if ();

  hashed_trie_node_table_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  always #10 clk_i = ~clk_i;

  // shadow copy of the node table and its bookkeeping
  entry_t             node_tbl [SLOTS];
  logic [EPOCH_W-1:0] cur_epoch;
  logic [CNT_W-1:0]   live_cnt;
  logic [CNT_W-1:0]   room_left;

  answer_t           answers_due [$];
  key_t              recent_keys [$];
  logic [NODE_W-1:0] known_nodes [$];

  int      mismatches  = 0;
  int      idle_cycles = 0;
  bit      calm        = 1'b0;  // no idling on either side
  bit      rsp_hold_req = 1'b0;
  bit      typed_now   = 1'b0;
  answer_t typed_answer = NO_ANSWER;

  function automatic void reset_model();
    foreach (node_tbl[i]) node_tbl[i] = ENTRY_EMPTY;
    node_tbl[0] = ENTRY_ROOT;
    cur_epoch = EPOCH_FIRST;
    live_cnt  = '0;
    room_left = {1'b0, LOAD_LIMIT_RST};
  endfunction

  // expected result of one request, updating the shadow table on the way
  function automatic answer_t resolve_request(req_e rq, logic [NODE_W-1:0] node,
                                              logic [WORD_W-1:0] word);
    logic [31:0]             h;
    logic [LOG_SIZE_DEF-1:0] idx;
    logic [LOG_SIZE_DEF-1:0] stride;
    logic [EPOCH_W-1:0]      e;
    bit                      stopped;
    bit                      hit;
    answer_t                 a;
    h       = 32'(node) * HASH_MUL;
    idx     = h[LOG_SIZE_DEF-1:0] ^ word[LOG_SIZE_DEF-1:0];
    stride  = word[LOG_SIZE_DEF-1:0] | LOG_SIZE_DEF'(1);
    stopped = 1'b0;
    hit     = 1'b0;
    a.child = '0;

    if (rq == REQ_CLEAR) begin
      live_cnt = '0;
      // epoch wrap: sweep everything but persistent entries
      if (cur_epoch == EPOCH_LAST) begin
        foreach (node_tbl[i]) if (node_tbl[i].epoch != EPOCH_PERSIST) node_tbl[i] = ENTRY_EMPTY;
        cur_epoch = EPOCH_FIRST;
      end else begin
        cur_epoch = cur_epoch + 1'b1;
      end
      a.status = ST_CLEAR_DONE;
      return a;
    end

    if (rq == REQ_PERSISTENT) begin
      a.status = ST_OVERFLOW;  // full table with no usable slot
      for (int n = 0; n < SLOTS; n++) begin
        if (node_tbl[idx].epoch != EPOCH_PERSIST) begin
          stopped = 1'b1;
          break;
        end
        if (node_tbl[idx].parent == node && node_tbl[idx].word == word) begin
          hit = 1'b1;
          break;
        end
        idx = idx + stride;
      end
      if (hit) begin
        a.child  = NODE_W'(idx);
        a.status = ST_FOUND;
      end else if (stopped) begin
        node_tbl[idx] = '{parent: node, word: word, epoch: EPOCH_PERSIST};
        if (room_left != 0) room_left = room_left - 1'b1;
        a.child = NODE_W'(idx);
        if (live_cnt > room_left) a.status = ST_OVERFLOW;
        else a.status = ST_INSERTED;
      end
      return a;
    end

    if (rq == REQ_EPHEMERAL) a.status = ST_OVERFLOW;
    else a.status = ST_NOT_FOUND;
    for (int n = 0; n < SLOTS; n++) begin
      e = node_tbl[idx].epoch;
      if (e == EPOCH_PERSIST || e == cur_epoch) begin
        if (node_tbl[idx].parent == node && node_tbl[idx].word == word) begin
          a.child  = NODE_W'(idx);
          a.status = ST_FOUND;
          break;
        end
      end else begin
        // first free or stale slot ends the walk
        if (rq == REQ_EPHEMERAL) begin
          node_tbl[idx] = '{parent: node, word: word, epoch: cur_epoch};
          if (live_cnt < COUNT_MAX) live_cnt = live_cnt + 1'b1;
          a.child = NODE_W'(idx);
          if (live_cnt > room_left) a.status = ST_OVERFLOW;
          else a.status = ST_INSERTED;
        end else begin
          a.status = ST_NOT_FOUND;
        end
        break;
      end
      idx = idx + stride;
    end
    return a;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("%0t ns: mismatch, %s", $time, what);
  endtask

  // everything observed at the rising edge
  always @(posedge clk_i) begin : observe
    answer_t due;
    bit      moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        room_left = {1'b0, cfg_if.load_limit};
        moved     = 1'b1;
      end
      if (req_if.valid && req_if.ready) begin
        due = resolve_request(req_if.req_type, req_if.parent_node, req_if.edge_word);
        // remember children so later items can hang below them
        if (due.child != 0) begin
          known_nodes.push_back(due.child);
          if (known_nodes.size() > NODE_KEEP) void'(known_nodes.pop_front());
        end
        if (typed_now) due = typed_answer;
        answers_due.push_back(due);
        moved = 1'b1;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        moved = 1'b1;
        if (answers_due.size() == 0) begin
          report_mismatch($sformatf("unexpected item child %0d status %0d",
                                    rsp_if.child_node, rsp_if.status));
        end else begin
          due = answers_due.pop_front();
          if (rsp_if.child_node !== due.child)
            report_mismatch($sformatf("child_node %0d, predicted %0d",
                                      rsp_if.child_node, due.child));
          if (rsp_if.status !== due.status)
            report_mismatch($sformatf("status %0d, predicted %0d",
                                      rsp_if.status, due.status));
        end
      end
    end
    if (moved) idle_cycles = 0;
    else idle_cycles = idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side: random stalls, plus one long hold on request
  initial begin : result_sink
    int n;
    rsp_if.ready = 1'b0;
    @(negedge clk_i);
    forever begin
      if (rsp_hold_req) begin
        rsp_hold_req = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (RSP_HOLD) @(negedge clk_i);
      end else if (calm) begin
        rsp_if.ready <= 1'b1;
        @(negedge clk_i);
      end else begin
        n = draw_gap();
        if (n > 0) begin
          rsp_if.ready <= 1'b0;
          repeat (n) @(negedge clk_i);
        end
        rsp_if.ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer_request(req_e rq, logic [NODE_W-1:0] node, logic [WORD_W-1:0] word,
                               bit typed, answer_t fixed);
    typed_now    = typed;
    typed_answer = fixed;
    req_if.req_type    <= rq;
    req_if.parent_node <= node;
    req_if.edge_word   <= word;
    req_if.valid       <= 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic idle_sender(int gap);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // stop offering and wait until every result is back
  task automatic settle();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (answers_due.size() != 0);
  endtask

  task automatic write_load_limit(logic [LIMIT_W-1:0] value);
    cfg_if.load_limit <= value;
    cfg_if.valid      <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // keys: reuse of earlier keys, crowded home slots, or fully random
  task automatic pick_key(bit crowd, output logic [NODE_W-1:0] node,
                          output logic [WORD_W-1:0] word);
    int   r;
    key_t k;
    r = $urandom_range(0, 99);
    if (recent_keys.size() > 0 && r < 45) begin
      k    = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      node = k.node;
      word = k.word;
    end else if (r < (crowd ? 90 : 70)) begin
      // fixed parent and low word bits share a home slot, long probe chains
      if (known_nodes.size() > 0 && $urandom_range(0, 1) == 1)
        node = known_nodes[$urandom_range(0, known_nodes.size() - 1)];
      else
        node = NODE_W'($urandom_range(0, 3));
      word = {12'($urandom), 12'(12'h555 * $urandom_range(0, 3))};
    end else begin
      node = NODE_W'($urandom);
      word = WORD_W'($urandom);
    end
  endtask

  task automatic run_phase(logic [LIMIT_W-1:0] limit, int count, int clear_pct, bit crowd,
                           bit quiet, int hold_at, int drain_at);
    int                r;
    req_e              rq;
    logic [NODE_W-1:0] node;
    logic [WORD_W-1:0] word;
    settle();
    write_load_limit(limit);
    calm = quiet;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) rsp_hold_req = 1'b1;
      if (i == drain_at) settle();
      r = $urandom_range(0, 99);
      if (r < clear_pct) begin
        rq = REQ_CLEAR;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 48) rq = REQ_EPHEMERAL;
        else if (r < 60) rq = REQ_PERSISTENT;
        else rq = REQ_LOOKUP;
      end
      pick_key(crowd, node, word);
      if (rq == REQ_EPHEMERAL || rq == REQ_PERSISTENT) begin
        recent_keys.push_back('{node: node, word: word});
        if (recent_keys.size() > KEY_KEEP) void'(recent_keys.pop_front());
      end
      offer_request(rq, node, word, 1'b0, NO_ANSWER);
      idle_sender(draw_gap());
    end
    calm = 1'b0;
  endtask

  initial begin : stimulus
    answer_t fixed;
    reset_model();
    rst_ni               = 1'b0;
    req_if.valid         = 1'b0;
    req_if.req_type      = REQ_LOOKUP;
    req_if.parent_node   = '0;
    req_if.edge_word     = '0;
    cfg_if.valid         = 1'b0;
    cfg_if.load_limit    = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed items at the reset load limit
    for (int i = 0; i < N_ROWS; i++) begin
      fixed = '{child: DIRECTED[i].child, status: DIRECTED[i].status};
      offer_request(DIRECTED[i].rq, DIRECTED[i].node, DIRECTED[i].word,
                    DIRECTED[i].typed, fixed);
      idle_sender(draw_gap());
    end

    // limit, items, clear %, crowded keys, no idling, long result hold, sender drain
    run_phase(12'hFFF, 380, 2, 1'b0, 1'b0, 100, -1);
    run_phase(12'd1, 220, 10, 1'b1, 1'b0, -1, -1);
    // clear-heavy stretch drives the epoch through its wrap and sweep
    run_phase(LIMIT_W'($urandom_range(2, 40)), 330, 85, 1'b0, 1'b0, -1, -1);
    run_phase(12'd2048, 400, 4, 1'b1, 1'b0, -1, 200);
    run_phase(LIMIT_W'($urandom_range(1, 4095)), 320, 8, 1'b1, 1'b1, -1, -1);

    settle();
    repeat (20) @(negedge clk_i);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> hashed_trie_node_table_core.f
hw/rtl/htnt_pkg.sv
hw/rtl/htnt_if.sv
hw/rtl/htnt_mem.sv
hw/rtl/htnt_hash.sv
hw/rtl/htnt_ctrl.sv
hw/rtl/hashed_trie_node_table_core.sv
hw/rtl/htnt_checker.sv
verif/tb_top.sv
